### design/hsl_pkg.sv
// Shared types for the HSL to RGB converter.
// Holds the hue sector code; no dependencies.
package hsl_pkg;

    // Hue sector: which sixth of the color wheel a pixel falls in
    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

endpackage

### design/hsl_to_rgb_converter.sv
// HSL to RGB converter, four register stages, one pixel per cycle.
// An accepted pixel moves through the stage 1, 2, 3 and 4 registers; m_valid is the stage 4 valid bit.
// Throughput: one pixel per cycle unless m_ready stalls a full pipeline; the two chained multipliers set the stage cut.
// Stalls on m_ready back up through per-stage valid bits, nothing dropped.
// Reset (aresetn low, synchronous) empties all stages; payload is not reset.
// Depends on hsl_pkg for the sector code.
module hsl_to_rgb_converter #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_hue,
    input  logic [CHANNEL_BITS-1:0] s_saturation,
    input  logic [CHANNEL_BITS-1:0] s_lightness,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHANNEL_BITS-1:0] m_red,
    output logic [CHANNEL_BITS-1:0] m_green,
    output logic [CHANNEL_BITS-1:0] m_blue
);

    localparam int N = CHANNEL_BITS;

    // Stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: lightness tent k, hue sector and hue tent w
    logic [N:0]          two_l, k1_next, f2, w1_next;
    logic [N+2:0]        hs;
    hsl_pkg::sector_t    sec1_next;
    logic [N:0]          k1_reg, w1_reg;
    logic [N-1:0]        s1_reg, l1_reg;
    hsl_pkg::sector_t    sec1_reg;

    always_comb begin
        two_l     = {s_lightness, 1'b0};
        k1_next   = s_lightness[N-1] ? ((~two_l) + 1'b1) : two_l;
        hs        = {1'b0, s_hue, 2'b00} + {2'b00, s_hue, 1'b0};
        sec1_next = hsl_pkg::sector_t'(hs[N+2:N]);
        f2        = hs[N:0];
        w1_next   = f2[N] ? ((~f2) + 1'b1) : f2;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            k1_reg   <= k1_next;
            w1_reg   <= w1_next;
            s1_reg   <= s_saturation;
            l1_reg   <= s_lightness;
            sec1_reg <= sec1_next;
        end
    end

    // Stage 2: chroma C = (k * S) >> N
    logic [2*N:0]     prod_c;
    logic [N-1:0]     c2_next, c2_reg, l2_reg;
    logic [N:0]       w2_reg;
    hsl_pkg::sector_t sec2_reg;

    always_comb begin
        prod_c  = k1_reg * {1'b0, s1_reg};
        c2_next = prod_c[2*N-1:N];
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            c2_reg   <= c2_next;
            l2_reg   <= l1_reg;
            w2_reg   <= w1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    // Stage 3: secondary X = (C * w) >> N and offset m = L - C/2
    logic [2*N:0]     prod_x;
    logic [N-1:0]     half_c, x3_next, m3_next;
    logic [N-1:0]     c3_reg, x3_reg, m3_reg;
    hsl_pkg::sector_t sec3_reg;

    always_comb begin
        prod_x  = {1'b0, c2_reg} * w2_reg;
        x3_next = prod_x[2*N-1:N];
        half_c  = c2_reg >> 1;
        m3_next = (l2_reg >= half_c) ? (l2_reg - half_c) : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            c3_reg   <= c2_reg;
            x3_reg   <= x3_next;
            m3_reg   <= m3_next;
            sec3_reg <= sec2_reg;
        end
    end

    // Stage 4: place C and X per sector, add m, saturate
    logic [N-1:0] r_raw, g_raw, b_raw;
    logic [N:0]   r_sum, g_sum, b_sum;
    logic [N-1:0] red_next, green_next, blue_next;
    logic [N-1:0] red_reg, green_reg, blue_reg;

    always_comb begin
        case (sec3_reg)
            hsl_pkg::SECT_RED_YEL: begin
                r_raw = c3_reg; g_raw = x3_reg; b_raw = '0;
            end
            hsl_pkg::SECT_YEL_GRN: begin
                r_raw = x3_reg; g_raw = c3_reg; b_raw = '0;
            end
            hsl_pkg::SECT_GRN_CYN: begin
                r_raw = '0; g_raw = c3_reg; b_raw = x3_reg;
            end
            hsl_pkg::SECT_CYN_BLU: begin
                r_raw = '0; g_raw = x3_reg; b_raw = c3_reg;
            end
            hsl_pkg::SECT_BLU_MAG: begin
                r_raw = x3_reg; g_raw = '0; b_raw = c3_reg;
            end
            default: begin
                r_raw = c3_reg; g_raw = '0; b_raw = x3_reg;
            end
        endcase
        r_sum      = {1'b0, r_raw} + {1'b0, m3_reg};
        g_sum      = {1'b0, g_raw} + {1'b0, m3_reg};
        b_sum      = {1'b0, b_raw} + {1'b0, m3_reg};
        red_next   = r_sum[N] ? '1 : r_sum[N-1:0];
        green_next = g_sum[N] ? '1 : g_sum[N-1:0];
        blue_next  = b_sum[N] ? '1 : b_sum[N-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

### design/hsl_checker.sv
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends only on the top level's ports.
module hsl_checker #(
    parameter int CHANNEL_BITS = 16
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [CHANNEL_BITS-1:0] m_red,
    input logic [CHANNEL_BITS-1:0] m_green,
    input logic [CHANNEL_BITS-1:0] m_blue
);

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped while stalled");

    // Hold stalled result payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_red) && $stable(m_green) && $stable(m_blue))
        else $error("result payload changed while stalled");

    // Drain the pipeline on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Keep accepting while the sink takes results
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

endmodule

bind hsl_to_rgb_converter hsl_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hsl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_red   (m_red),
    .m_green (m_green),
    .m_blue  (m_blue)
);
